// ===== hdl/q2rm_pkg.sv =====
package q2rm_pkg;

   localparam int COMP_WIDTH    = 16;
   localparam int OUT_FRAC_BITS = 30;
   localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
   // squared magnitude width: 4 * 2^30 fits in 33 bits
   localparam int DEN_WIDTH     = 2 * COMP_WIDTH + 1;
   // numerator magnitude 2*(sum of two products) <= 2^32
   localparam int NUM_WIDTH     = 2 * COMP_WIDTH + 1;
   localparam int QUO_WIDTH     = OUT_FRAC_BITS + 2;
   localparam int REM_WIDTH     = DEN_WIDTH + 1;
   localparam int NUM_ENTRIES   = 9;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] q_real;
      logic signed [COMP_WIDTH-1:0] q_i;
      logic signed [COMP_WIDTH-1:0] q_j;
      logic signed [COMP_WIDTH-1:0] q_k;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] m00;
      logic signed [OUT_WIDTH-1:0] m01;
      logic signed [OUT_WIDTH-1:0] m02;
      logic signed [OUT_WIDTH-1:0] m10;
      logic signed [OUT_WIDTH-1:0] m11;
      logic signed [OUT_WIDTH-1:0] m12;
      logic signed [OUT_WIDTH-1:0] m20;
      logic signed [OUT_WIDTH-1:0] m21;
      logic signed [OUT_WIDTH-1:0] m22;
      logic                        degenerate;
   } rsp_type;

   // one restoring divider lane as it travels down the pipe
   typedef struct packed {
      logic [REM_WIDTH-1:0] rem;
      logic [QUO_WIDTH-1:0] quo;
      logic                 neg;
      logic                 diag;
   } lane_type;

endpackage

// ===== hdl/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix, fully pipelined.
//
// Input channel: drive req_data (q_real, q_i, q_j, q_k, signed Q1.15) and
// pulse start; the item is taken at the edge where start is high and busy is
// low. busy is tied low: the block takes one item in every cycle.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data
// (nine signed Q2.30 entries, row major, and a degenerate flag). The
// receiver cannot stall, so no item ever waits inside the block.
//
// Pipeline: one stage of squares and products, one of sums and signs, one of
// the two integer quotient steps, thirty restoring quotient-bit stages (one
// bit per stage across nine lanes), and one output stage.
// Throughput: one item per cycle; nine divider lanes run side by side.
// An all-zero quaternion gives the identity matrix with degenerate set.
// Reset clears only the valid bits; data registers carry no reset.
module quaternion_to_rotation_matrix (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  q2rm_pkg::req_type        req_data,
   output logic                     rsp_valid,
   output q2rm_pkg::rsp_type        rsp_data
);

   localparam int CW = q2rm_pkg::COMP_WIDTH;
   localparam int PW = 2 * CW;
   localparam int DW = q2rm_pkg::DEN_WIDTH;
   localparam int NW = q2rm_pkg::NUM_WIDTH;
   localparam int RW = q2rm_pkg::REM_WIDTH;
   localparam int QW = q2rm_pkg::QUO_WIDTH;
   localparam int FB = q2rm_pkg::OUT_FRAC_BITS;
   localparam int NE = q2rm_pkg::NUM_ENTRIES;
   localparam int OW = q2rm_pkg::OUT_WIDTH;

   assign busy = 1'b0;

   // ---------------- stage 1: products ----------------
   logic                 v1_ff;
   logic signed [PW-1:0] sq_ff [4];   // rr ii jj kk
   logic signed [PW-1:0] pr_ff [6];   // ij kr ik jr jk ir

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      sq_ff[0] <= req_data.q_real * req_data.q_real;
      sq_ff[1] <= req_data.q_i * req_data.q_i;
      sq_ff[2] <= req_data.q_j * req_data.q_j;
      sq_ff[3] <= req_data.q_k * req_data.q_k;
      pr_ff[0] <= req_data.q_i * req_data.q_j;
      pr_ff[1] <= req_data.q_k * req_data.q_real;
      pr_ff[2] <= req_data.q_i * req_data.q_k;
      pr_ff[3] <= req_data.q_j * req_data.q_real;
      pr_ff[4] <= req_data.q_j * req_data.q_k;
      pr_ff[5] <= req_data.q_i * req_data.q_real;
   end

   // ---------------- stage 2: sums, magnitudes, signs ----------------
   logic          v2_ff;
   logic [DW-1:0] den_ff;
   logic [NW-1:0] num_ff [NE];
   logic          neg_ff [NE];
   logic          dg_ff;

   logic [DW-1:0]        den_in;
   logic signed [PW+1:0] raw_in [NE];

   always_comb begin
      den_in = DW'(sq_ff[0]) + DW'(sq_ff[1]) + DW'(sq_ff[2]) + DW'(sq_ff[3]);
      // diagonal entries carry the square sums
      raw_in[0] = (PW+2)'(sq_ff[2]) + (PW+2)'(sq_ff[3]);
      raw_in[4] = (PW+2)'(sq_ff[1]) + (PW+2)'(sq_ff[3]);
      raw_in[8] = (PW+2)'(sq_ff[1]) + (PW+2)'(sq_ff[2]);
      raw_in[1] = (PW+2)'(pr_ff[0]) - (PW+2)'(pr_ff[1]);
      raw_in[3] = (PW+2)'(pr_ff[0]) + (PW+2)'(pr_ff[1]);
      raw_in[2] = (PW+2)'(pr_ff[2]) + (PW+2)'(pr_ff[3]);
      raw_in[6] = (PW+2)'(pr_ff[2]) - (PW+2)'(pr_ff[3]);
      raw_in[5] = (PW+2)'(pr_ff[4]) - (PW+2)'(pr_ff[5]);
      raw_in[7] = (PW+2)'(pr_ff[4]) + (PW+2)'(pr_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      den_ff <= den_in;
      dg_ff  <= (den_in == '0);
      for (int e = 0; e < NE; e++) begin
         neg_ff[e] <= raw_in[e][PW+1];
         num_ff[e] <= raw_in[e][PW+1] ? NW'(-raw_in[e]) : NW'(raw_in[e]);
      end
   end

   // ---------------- stage 3: integer bits (numerator 2*num) ----------------
   // Quotient of 2*num/den is at most 2: two compare-subtract steps.
   // This stage fills index 0 of the divider pipe below.
   logic               vs_ff  [FB+1];
   q2rm_pkg::lane_type ls_ff  [FB+1][NE];
   logic [DW-1:0]      ds_ff  [FB+1];
   logic               gs_ff  [FB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff[0] <= 1'b0;
      end else begin
         vs_ff[0] <= v2_ff;
      end
      ds_ff[0] <= den_ff;
      gs_ff[0] <= dg_ff;
      for (int e = 0; e < NE; e++) begin
         logic [RW-1:0] r;
         logic [1:0]    q;
         r = {num_ff[e], 1'b0};
         q = 2'd0;
         if (r >= RW'(den_ff)) begin
            r = r - RW'(den_ff);
            q = 2'd1;
         end
         if (r >= RW'(den_ff)) begin
            r = r - RW'(den_ff);
            q = q + 2'd1;
         end
         ls_ff[0][e].rem  <= r;
         ls_ff[0][e].quo  <= QW'(q);
         ls_ff[0][e].neg  <= neg_ff[e];
         ls_ff[0][e].diag <= (e == 0) || (e == 4) || (e == 8);
      end
   end

   // ---------------- fraction stages: one quotient bit each ----------------
   for (genvar s = 0; s < FB; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[s+1] <= 1'b0;
         end else begin
            vs_ff[s+1] <= vs_ff[s];
         end
         ds_ff[s+1] <= ds_ff[s];
         gs_ff[s+1] <= gs_ff[s];
         for (int e = 0; e < NE; e++) begin
            logic [RW-1:0] r;
            logic          b;
            r = {ls_ff[s][e].rem[RW-2:0], 1'b0};
            b = (r >= RW'(ds_ff[s]));
            if (b) begin
               r = r - RW'(ds_ff[s]);
            end
            ls_ff[s+1][e].rem  <= r;
            ls_ff[s+1][e].quo  <= {ls_ff[s][e].quo[QW-2:0], b};
            ls_ff[s+1][e].neg  <= ls_ff[s][e].neg;
            ls_ff[s+1][e].diag <= ls_ff[s][e].diag;
         end
      end
   end

   // ---------------- output stage ----------------
   logic              vo_ff;
   q2rm_pkg::rsp_type ro_ff;
   logic [OW-1:0]     ent_in [NE];
   localparam logic [OW-1:0] ONE = OW'(1) << FB;

   always_comb begin
      for (int e = 0; e < NE; e++) begin
         if (gs_ff[FB]) begin
            ent_in[e] = ls_ff[FB][e].diag ? ONE : '0;
         end else if (ls_ff[FB][e].diag) begin
            ent_in[e] = ONE - OW'(ls_ff[FB][e].quo);
         end else if (ls_ff[FB][e].neg) begin
            ent_in[e] = OW'(-ls_ff[FB][e].quo);
         end else begin
            ent_in[e] = OW'(ls_ff[FB][e].quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= vs_ff[FB];
      end
      ro_ff.m00 <= ent_in[0];
      ro_ff.m01 <= ent_in[1];
      ro_ff.m02 <= ent_in[2];
      ro_ff.m10 <= ent_in[3];
      ro_ff.m11 <= ent_in[4];
      ro_ff.m12 <= ent_in[5];
      ro_ff.m20 <= ent_in[6];
      ro_ff.m21 <= ent_in[7];
      ro_ff.m22 <= ent_in[8];
      ro_ff.degenerate <= gs_ff[FB];
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = ro_ff;

   // ---------------- assertions ----------------
   a_deg_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.m00 == ONE && rsp_data.m01 == '0
         && rsp_data.m11 == ONE && rsp_data.m22 == ONE)
      else $error("degenerate item must give identity");

   a_deg_zero_den: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> dg_ff == (den_ff == '0))
      else $error("degenerate flag disagrees with norm");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vs_ff[0] && !gs_ff[0] |-> ls_ff[0][0].rem < RW'(ds_ff[0]))
      else $error("remainder not reduced below norm");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      v2_ff |=> vs_ff[0])
      else $error("valid bit lost in pipe");

endmodule
